### design/two_band_directivity_fractional_delay_macros.svh
// assertion macros used by the checker file
`ifndef TWO_BAND_DIRECTIVITY_FRACTIONAL_DELAY_MACROS_SVH
`define TWO_BAND_DIRECTIVITY_FRACTIONAL_DELAY_MACROS_SVH

// clocked check, off while reset is low
`define TBDFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define TBDFD_ASSERT_NEVER(lbl, expr, msg) \
  `TBDFD_ASSERT(lbl, !(expr), msg)

`endif

### design/tbdfd_pkg.sv
package tbdfd_pkg;

  localparam int DelayDepth   = 4096;
  localparam int SampleWidth  = 24;
  localparam int FractionBits = 8;

  localparam int AddrW = $clog2(DelayDepth);

  // register field widths
  localparam int CoefW  = 19;
  localparam int DirW   = 19;
  localparam int ScaleW = 21;
  localparam int DelayW = 20;

  localparam int GainShift  = 18;
  localparam int ScaleShift = 16;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 21;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_COEF     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LDIR     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RDIR     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LSCALE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RSCALE   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LDELAY   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RDELAY   = 3'd6;

  localparam logic [CoefW-1:0]  COEF_RESET  = 19'd131072;
  localparam logic [DirW-1:0]   DIR_RESET   = 19'd262144;
  localparam logic [ScaleW-1:0] SCALE_RESET = 21'd65536;
  localparam logic [DelayW-1:0] DELAY_RESET = 20'd0;

  // sequencer steps
  localparam int StW = 3;
  localparam logic [StW-1:0] ST_IDLE = 3'd0;
  localparam logic [StW-1:0] ST_MUL1 = 3'd1;
  localparam logic [StW-1:0] ST_LOW  = 3'd2;
  localparam logic [StW-1:0] ST_MUL2 = 3'd3;
  localparam logic [StW-1:0] ST_MUL3 = 3'd4;
  localparam logic [StW-1:0] ST_DONE = 3'd5;

  typedef struct packed {
    logic [StW-1:0]   step;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr_a;
    logic [AddrW-1:0] rd_addr_b;
    logic             live_a;
    logic             live_b;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
  } tbdfd_ctl_t;

endpackage

### design/tbdfd_in_if.sv
interface tbdfd_in_if import tbdfd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] source_sample;

  modport source (output valid, output source_sample, input ready);
  modport sink (input valid, input source_sample, output ready);
endinterface

### design/tbdfd_out_if.sv
interface tbdfd_out_if import tbdfd_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] left_sample;
  logic signed [SampleWidth-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

### design/tbdfd_lane.sv
module tbdfd_lane import tbdfd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbdfd_ctl_t                    ctl_i,
  input  logic signed [SampleWidth-1:0] x_i,
  input  logic [CoefW-1:0]              coef_i,
  input  logic [DirW-1:0]               dir_i,
  input  logic [ScaleW-1:0]             scale_i,
  input  logic [FractionBits-1:0]       frac_i,
  output logic signed [SampleWidth-1:0] out_o
);

  localparam int DW    = SampleWidth + 1;
  localparam int P1W   = DW + CoefW + 1;
  localparam int P2W   = DW + DirW + 1;
  localparam int PropW = P2W - GainShift + 1;
  localparam int P3W   = PropW + ScaleW + 1;
  localparam int IpW   = DW + FractionBits + 1;

  localparam logic signed [63:0] SatMax64 = (64'sd1 <<< (SampleWidth - 1)) - 64'sd1;
  localparam logic signed [63:0] SatMin64 = -SatMax64 - 64'sd1;

  localparam logic [CoefW-1:0] GainOne = CoefW'(1) << GainShift;

  logic signed [SampleWidth-1:0] mem_q [DelayDepth];

  logic signed [SampleWidth-1:0] rda_q, rdb_q, a_q, low_q, out_q;
  logic                          live_a_q, live_b_q;
  logic signed [P1W-1:0]         p1_q;
  logic signed [P2W-1:0]         p2_q;
  logic signed [P3W-1:0]         p3_q;
  logic signed [IpW-1:0]         ip_q;

  logic [CoefW-1:0]              coef_eff;
  logic signed [SampleWidth-1:0] a_eff, b_eff;
  logic signed [DW-1:0]          diff_lp, diff_ab, high;
  logic signed [P1W-1:0]         p1_d, p1_rnd;
  logic signed [IpW-1:0]         ip_d, ip_rnd, interp;
  logic signed [P2W-1:0]         p2_d, p2_rnd;
  logic signed [PropW-1:0]       prop1;
  logic signed [P3W-1:0]         p3_d, p3_rnd;
  logic signed [SampleWidth-1:0] low_d, interp_sat, prop_sat;

  // delay line, two read ports and one write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr] <= prop_sat;
    end
    if (ctl_i.rd_en) begin
      rda_q    <= mem_q[ctl_i.rd_addr_a];
      rdb_q    <= mem_q[ctl_i.rd_addr_b];
      live_a_q <= ctl_i.live_a;
      live_b_q <= ctl_i.live_b;
    end
  end

  // slots not yet written read as zero
  assign a_eff = live_a_q ? rda_q : '0;
  assign b_eff = live_b_q ? rdb_q : '0;

  assign coef_eff = (coef_i > GainOne) ? GainOne : coef_i;
  assign diff_lp  = DW'(x_i) - DW'(low_q);
  assign diff_ab  = DW'(b_eff) - DW'(a_eff);
  assign p1_d     = P1W'(diff_lp) * P1W'($signed({1'b0, coef_eff}));
  assign ip_d     = IpW'(diff_ab) * IpW'($signed({1'b0, frac_i}));

  // round half up, then floor
  assign p1_rnd = (p1_q + P1W'(64'sd1 <<< (GainShift - 1))) >>> GainShift;
  assign low_d  = low_q + p1_rnd[SampleWidth-1:0];

  assign ip_rnd = (ip_q + IpW'(64'sd1 <<< (FractionBits - 1))) >>> FractionBits;
  assign interp = IpW'(a_q) + ip_rnd;

  always_comb begin
    if (interp > IpW'(SatMax64)) begin
      interp_sat = SampleWidth'(SatMax64);
    end else if (interp < IpW'(SatMin64)) begin
      interp_sat = SampleWidth'(SatMin64);
    end else begin
      interp_sat = interp[SampleWidth-1:0];
    end
  end

  assign high   = DW'(x_i) - DW'(low_q);
  assign p2_d   = P2W'(high) * P2W'($signed({1'b0, dir_i}));
  assign p2_rnd = (p2_q + P2W'(64'sd1 <<< (GainShift - 1))) >>> GainShift;
  assign prop1  = PropW'(low_q) + p2_rnd[PropW-1:0];
  assign p3_d   = P3W'(prop1) * P3W'($signed({1'b0, scale_i}));
  assign p3_rnd = (p3_q + P3W'(64'sd1 <<< (ScaleShift - 1))) >>> ScaleShift;

  always_comb begin
    if (p3_rnd > P3W'(SatMax64)) begin
      prop_sat = SampleWidth'(SatMax64);
    end else if (p3_rnd < P3W'(SatMin64)) begin
      prop_sat = SampleWidth'(SatMin64);
    end else begin
      prop_sat = p3_rnd[SampleWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step == ST_MUL1) begin
      p1_q <= p1_d;
      ip_q <= ip_d;
      a_q  <= a_eff;
    end
    if (ctl_i.step == ST_LOW) begin
      out_q <= interp_sat;
    end
    if (ctl_i.step == ST_MUL2) begin
      p2_q <= p2_d;
    end
    if (ctl_i.step == ST_MUL3) begin
      p3_q <= p3_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= '0;
    end else if (ctl_i.step == ST_LOW) begin
      low_q <= low_d;
    end
  end

  assign out_o = out_q;

endmodule

### design/two_band_directivity_fractional_delay.sv
// path: a result is registered through the steps MUL1, LOW, MUL2, MUL3 and DONE after the source beat
// pacing: one source beat at a time, taken again only once DONE hands on its result, set by the
//   three dependent multiplies of the low-pass, directivity and distance chain after the delay line read
// reset: registers return to their defaults, low bands and write pointer clear,
//   delay lines read as zero until written (fill tracking, no clearing pass)
module two_band_directivity_fractional_delay import tbdfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  tbdfd_in_if.sink            in_i,
  tbdfd_out_if.source         out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CoefW-1:0]  coef_q;
  logic [DirW-1:0]   ldir_q, rdir_q;
  logic [ScaleW-1:0] lscale_q, rscale_q;
  logic [DelayW-1:0] ldelay_q, rdelay_q;

  logic [StW-1:0]   state_q, state_d;
  logic [AddrW-1:0] wp_q;
  logic             wrapped_q;
  logic             out_valid_q;

  logic signed [SampleWidth-1:0] x_q, left_q, right_q, lane_l, lane_r;

  logic             in_acc, done_fire;
  logic [AddrW-1:0] n_l, n_r, ra_l, rb_l, ra_r, rb_r;
  tbdfd_ctl_t       ctl_l, ctl_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= COEF_RESET;
      ldir_q   <= DIR_RESET;
      rdir_q   <= DIR_RESET;
      lscale_q <= SCALE_RESET;
      rscale_q <= SCALE_RESET;
      ldelay_q <= DELAY_RESET;
      rdelay_q <= DELAY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COEF:   coef_q   <= cfg_data_i[CoefW-1:0];
        REG_LDIR:   ldir_q   <= cfg_data_i[DirW-1:0];
        REG_RDIR:   rdir_q   <= cfg_data_i[DirW-1:0];
        REG_LSCALE: lscale_q <= cfg_data_i[ScaleW-1:0];
        REG_RSCALE: rscale_q <= cfg_data_i[ScaleW-1:0];
        REG_LDELAY: ldelay_q <= cfg_data_i[DelayW-1:0];
        REG_RDELAY: rdelay_q <= cfg_data_i[DelayW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign done_fire  = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_LOW;
      ST_LOW:  state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_DONE;
      ST_DONE: if (done_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_fire) begin
        wp_q <= wp_q + AddrW'(1);
        if (wp_q == AddrW'(DelayDepth - 1)) begin
          wrapped_q <= 1'b1;
        end
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_i.source_sample;
    end
    if (done_fire) begin
      left_q  <= lane_l;
      right_q <= lane_r;
    end
  end

  // integer delay picks the newer tap, one slot older for the fraction
  assign n_l  = AddrW'(ldelay_q >> FractionBits);
  assign n_r  = AddrW'(rdelay_q >> FractionBits);
  assign ra_l = wp_q - n_l;
  assign rb_l = ra_l - AddrW'(1);
  assign ra_r = wp_q - n_r;
  assign rb_r = ra_r - AddrW'(1);

  always_comb begin
    ctl_l.step      = state_q;
    ctl_l.rd_en     = in_acc;
    ctl_l.rd_addr_a = ra_l;
    ctl_l.rd_addr_b = rb_l;
    ctl_l.live_a    = wrapped_q || (ra_l < wp_q);
    ctl_l.live_b    = wrapped_q || (rb_l < wp_q);
    ctl_l.wr_en     = done_fire;
    ctl_l.wr_addr   = wp_q;

    ctl_r.step      = state_q;
    ctl_r.rd_en     = in_acc;
    ctl_r.rd_addr_a = ra_r;
    ctl_r.rd_addr_b = rb_r;
    ctl_r.live_a    = wrapped_q || (ra_r < wp_q);
    ctl_r.live_b    = wrapped_q || (rb_r < wp_q);
    ctl_r.wr_en     = done_fire;
    ctl_r.wr_addr   = wp_q;
  end

  tbdfd_lane u_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_l),
    .x_i     (x_q),
    .coef_i  (coef_q),
    .dir_i   (ldir_q),
    .scale_i (lscale_q),
    .frac_i  (ldelay_q[FractionBits-1:0]),
    .out_o   (lane_l)
  );

  tbdfd_lane u_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_r),
    .x_i     (x_q),
    .coef_i  (coef_q),
    .dir_i   (rdir_q),
    .scale_i (rscale_q),
    .frac_i  (rdelay_q[FractionBits-1:0]),
    .out_o   (lane_r)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.left_sample  = left_q;
  assign out_o.right_sample = right_q;

endmodule

### design/tbdfd_checker.sv
`include "two_band_directivity_fractional_delay_macros.svh"

module tbdfd_checker import tbdfd_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SampleWidth-1:0] left_i,
  input logic [SampleWidth-1:0] right_i
);

  // one sample in flight: ready stays low through the whole chain
  `TBDFD_ASSERT(a_busy_after_beat, in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i, "input taken again while a sample is in flight")

  // a fresh result appears exactly at the pipeline depth after its input beat
  `TBDFD_ASSERT(a_result_timing, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 6), "result shown without a matching input beat")

  // stalled result holds
  `TBDFD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(left_i) && $stable(right_i), "stalled result changed")

  // no result can rise in the cycle right after an input beat
  `TBDFD_ASSERT_NEVER(a_no_early_result, $rose(out_valid_i) && $past(in_valid_i && in_ready_i), "result too early")

endmodule

bind two_band_directivity_fractional_delay tbdfd_checker u_tbdfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_i      (out_o.left_sample),
  .right_i     (out_o.right_sample)
);

### test/two_band_directivity_fractional_delay_tb.sv
module two_band_directivity_fractional_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbdfd_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam longint GainOne = longint'(1) << GainShift;
  localparam int SettleCycles = 10;
  localparam int HoldOffCycles = 200;
  localparam int QuietLimit = 2000;
  localparam int SourceTarget = 1450;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef struct packed {
    sample_t left;
    sample_t right;
  } sample_pair_t;

  class stereo_delay_model;
    logic [CoefW-1:0]  lp_coef;
    logic [DirW-1:0]   directivity [2];
    logic [ScaleW-1:0] dist_scale [2];
    logic [DelayW-1:0] tap_delay [2];
    longint            low_band [2];
    bit signed [SampleWidth-1:0] delay_line [2][DelayDepth];
    logic [AddrW-1:0]  wr_ptr;
    sample_pair_t      expected_pairs [$];
    int                failures;

    function new();
      lp_coef = COEF_RESET;
      directivity = '{DIR_RESET, DIR_RESET};
      dist_scale = '{SCALE_RESET, SCALE_RESET};
      tap_delay = '{DELAY_RESET, DELAY_RESET};
      low_band = '{0, 0};
      wr_ptr = '0;
      failures = 0;
    endfunction

    // add half, then floor
    function longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint sat(longint v);
      longint hi;
      hi = (longint'(1) << (SampleWidth - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_COEF:   lp_coef = data[CoefW-1:0];
        REG_LDIR:   directivity[0] = data[DirW-1:0];
        REG_RDIR:   directivity[1] = data[DirW-1:0];
        REG_LSCALE: dist_scale[0] = data[ScaleW-1:0];
        REG_RSCALE: dist_scale[1] = data[ScaleW-1:0];
        REG_LDELAY: tap_delay[0] = data[DelayW-1:0];
        REG_RDELAY: tap_delay[1] = data[DelayW-1:0];
        default: ;
      endcase
    endfunction

    function longint observe(int side, longint x);
      longint coef, hi_band, prop, a, b, frac;
      logic [AddrW-1:0] whole, r0, r1;
      // coefficient above one acts as one
      coef = (lp_coef > GainOne) ? GainOne : longint'(lp_coef);
      low_band[side] += rnd_shift((x - low_band[side]) * coef, GainShift);
      hi_band = x - low_band[side];
      prop = low_band[side] + rnd_shift(longint'(directivity[side]) * hi_band, GainShift);
      prop = sat(rnd_shift(prop * longint'(dist_scale[side]), ScaleShift));
      whole = tap_delay[side][FractionBits +: AddrW];
      frac = longint'(tap_delay[side][FractionBits-1:0]);
      r0 = wr_ptr - whole;
      r1 = r0 - 1'b1;
      // read the old contents before this beat is written
      a = delay_line[side][r0];
      b = delay_line[side][r1];
      delay_line[side][wr_ptr] = prop[SampleWidth-1:0];
      return sat(a + rnd_shift((b - a) * frac, FractionBits));
    endfunction

    function void take_source(sample_t x);
      sample_pair_t p;
      p.left = sample_t'(observe(0, longint'(x)));
      p.right = sample_t'(observe(1, longint'(x)));
      wr_ptr = wr_ptr + 1'b1;
      expected_pairs.push_back(p);
    endfunction

    function void check_pair(sample_t l, sample_t r);
      sample_pair_t e;
      if (expected_pairs.size() == 0) begin
        failures++;
        $display("%0t: unexpected result beat, left %0d right %0d", $time, l, r);
        return;
      end
      e = expected_pairs.pop_front();
      if (l !== e.left) begin
        failures++;
        $display("%0t: left_sample expected %0d actual %0d", $time, e.left, l);
      end
      if (r !== e.right) begin
        failures++;
        $display("%0t: right_sample expected %0d actual %0d", $time, e.right, r);
      end
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  tbdfd_in_if  in_if ();
  tbdfd_out_if out_if ();

  two_band_directivity_fractional_delay u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  stereo_delay_model   sb;
  logic [CfgDataW-1:0] reg_set [7];
  bit                  gaps_on;
  int                  hold_requests;
  int                  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [CfgDataW-1:0] rand_gain(int typical, int nominal_max);
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return CfgDataW'(nominal_max);
    // above the nominal range, upper data bits included
    if (pick < 28) return CfgDataW'($urandom_range(nominal_max + 1, (1 << CfgDataW) - 1));
    if (pick < 60) return CfgDataW'($urandom_range(0, typical));
    return CfgDataW'($urandom_range(0, nominal_max));
  endfunction

  function automatic logic [CfgDataW-1:0] rand_delay();
    int pick;
    logic [AddrW-1:0] whole;
    logic [FractionBits-1:0] frac;
    pick = $urandom_range(99);
    frac = FractionBits'($urandom);
    if (pick < 10) return '0;
    if (pick < 20) whole = '0;
    else if (pick < 70) whole = AddrW'($urandom_range(1, 40));
    else if (pick < 85) whole = AddrW'($urandom_range(DelayDepth - 6, DelayDepth - 1));
    else return CfgDataW'($urandom);
    return CfgDataW'({whole, frac});
  endfunction

  // entered and left at a falling edge
  task automatic send_sample(input sample_t s);
    while (gaps_on && $urandom_range(99) < 24) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.source_sample <= s;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.take_source(s);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apply_settings(input bit poke_unused);
    logic [CfgIdxW-1:0] idx [7];
    logic [CfgDataW-1:0] junk;
    idx = '{REG_COEF, REG_LDIR, REG_RDIR, REG_LSCALE, REG_RSCALE, REG_LDELAY, REG_RDELAY};
    for (int i = 0; i < 7; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= reg_set[i];
      sb.write_reg(idx[i], reg_set[i]);
    end
    if (poke_unused) begin
      junk = CfgDataW'($urandom);
      @(negedge clk_i);
      cfg_idx_i <= REG_UNUSED;
      cfg_data_i <= junk;
      sb.write_reg(REG_UNUSED, junk);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sink side: random stalls plus one long hold-off on request
  initial begin : sink_drive
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(gaps_on && $urandom_range(99) < 24);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_pair(out_if.left_sample, out_if.right_sample);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int phase;
    int count;
    int pick;
    int walk_level;
    sample_t s;
    sample_t probe [6];
    sb = new();
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.source_sample = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_COEF;
    cfg_data_i = '0;
    gaps_on = 1'b1;
    hold_requests = 0;
    quiet_cycles = 0;
    sent = 0;
    walk_level = 0;
    probe = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'shFFFFFF, 24'sh000001};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: default gains, top of range, zero gains, above range
    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: reg_set = '{COEF_RESET, DIR_RESET, DIR_RESET, SCALE_RESET, SCALE_RESET,
                       21'h000180, 21'h0003FF};
        1: reg_set = '{21'd262144, 21'd262144, 21'd262144, 21'd1310720, 21'd1310720,
                       21'h000100, 21'h0FFC00};
        // zero whole delay reads the slot about to be overwritten
        2: reg_set = '{21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'h000000, 21'h0000FF};
        default: reg_set = '{21'h1FFFFF, 21'd524287, 21'h1FFFFF, 21'h1FFFFF, 21'd1310721,
                             21'h0FFFFF, 21'h000080};
      endcase
      apply_settings(phase == 3);
      for (int k = 0; k < 6; k++) begin
        send_sample(probe[k]);
        sent++;
      end
    end

    while (sent < SourceTarget) begin
      wait_drained();
      reg_set[0] = rand_gain(32768, 262144);
      reg_set[1] = rand_gain(262144, 262144);
      reg_set[2] = rand_gain(262144, 262144);
      reg_set[3] = rand_gain(131072, 1310720);
      reg_set[4] = rand_gain(131072, 1310720);
      reg_set[5] = rand_delay();
      reg_set[6] = rand_delay();
      apply_settings($urandom_range(1));
      gaps_on = (phase != 5);
      count = $urandom_range(60, 160);
      for (int k = 0; k < count; k++) begin
        if (phase == 6 && k == 40) hold_requests++;
        if (phase == 7 && k == count / 2) wait_drained();
        pick = $urandom_range(99);
        if (pick < 10) begin
          case ($urandom_range(3))
            0: s = 24'sh7FFFFF;
            1: s = 24'sh800000;
            2: s = 24'sh000000;
            default: s = 24'shFFFFFF;
          endcase
        end else if (pick < 50) begin
          // slow random walk, audio-like content
          walk_level += int'($urandom_range(0, 65536)) - 32768;
          if (walk_level > 8388607) walk_level = 8388607;
          if (walk_level < -8388608) walk_level = -8388608;
          s = sample_t'(walk_level);
        end else if (pick < 70) begin
          s = sample_t'(int'($urandom_range(0, 4095)) - 2048);
        end else begin
          s = sample_t'($urandom);
        end
        send_sample(s);
        sent++;
      end
      phase++;
    end

    gaps_on = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
